/* hdl/impedance_gain_scheduler_core_defines.svh */
// ----------------------------------------------------------------------------
// Impedance gain scheduler assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IMPEDANCE_GAIN_SCHEDULER_CORE_DEFINES_SVH
`define IMPEDANCE_GAIN_SCHEDULER_CORE_DEFINES_SVH

// Same-cycle implication.
`define IGS_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define IGS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/igs_pkg.sv */
// ----------------------------------------------------------------------------
// Impedance gain scheduler package
// Field widths, register indexes, fixed-point constants and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package igs_pkg;

    // Field widths.
    localparam int PHASE_W = 2;
    localparam int K_W     = 18;
    localparam int POS_W   = 18;
    localparam int T_W     = 20;
    localparam int D_W     = 17;
    localparam int MASS_W  = 12;
    localparam int FAC_W   = 8;
    localparam int DEC_W   = 16;
    localparam int IDX_W   = 3;
    localparam int CFG_W   = 18;

    // Datapath widths.
    localparam int GAIN_W  = 17;
    localparam int KT_W    = K_W + T_W;
    localparam int KD_W    = K_W + DEC_W;
    localparam int NUM_W   = KT_W + GAIN_W;
    localparam int QUO_W   = 24;
    localparam int SCL_W   = 24;
    localparam int S_W     = 14;
    localparam int DIVR_W  = SCL_W + S_W;
    localparam int MR_W    = MASS_W + 16;

    // Phase codes.
    localparam logic [PHASE_W-1:0] PH_FREE     = 2'd0;
    localparam logic [PHASE_W-1:0] PH_INTERACT = 2'd1;
    localparam logic [PHASE_W-1:0] PH_RECOVER  = 2'd2;

    // Register indexes.
    localparam logic [IDX_W-1:0] REG_DEFAULT_K = 3'd0;
    localparam logic [IDX_W-1:0] REG_MIN_K     = 3'd1;
    localparam logic [IDX_W-1:0] REG_MAX_K     = 3'd2;
    localparam logic [IDX_W-1:0] REG_HEIGHT    = 3'd3;
    localparam logic [IDX_W-1:0] REG_MASS      = 3'd4;
    localparam logic [IDX_W-1:0] REG_OVERDAMP  = 3'd5;
    localparam logic [IDX_W-1:0] REG_DECAY     = 3'd6;

    // Constants: growth gain in Q1.16, interval limit, time scale, damping limit.
    localparam logic [GAIN_W-1:0] GAIN_Q16  = 17'd84157;
    localparam logic [T_W-1:0]    T_MAX     = 20'd1000000;
    localparam logic [SCL_W-1:0]  T_SCALE   = 24'd16000000;
    localparam logic [D_W-1:0]    DAMP_MAX  = 17'd131071;
    localparam logic [FAC_W-1:0]  FAC_TWO   = 8'd2;

    // Mass square root sequencer states.
    typedef enum logic [1:0] {
        RS_IDLE,
        RS_LOAD,
        RS_STEP,
        RS_SCALE
    } igs_root_state_t;

    // Sideband carried through the divider.
    typedef struct packed {
        logic [K_W-1:0] k;
        logic           grow;
        logic           interact;
    } igs_div_side_t;

    // Sideband carried through the square root pipeline.
    typedef struct packed {
        logic [K_W-1:0] k;
        logic           interact;
    } igs_sqrt_side_t;

endpackage

`default_nettype wire

/* hdl/igs_root_unit.sv */
// ----------------------------------------------------------------------------
// Mass square root sequencer
// Computes 16e6 * floor(sqrt(mass << 16)) one root bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module igs_root_unit #(
    parameter int SQRT_BITS = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [igs_pkg::MASS_W-1:0] mass,
    output logic                       busy,
    output logic [igs_pkg::DIVR_W-1:0] divisor
);

    import igs_pkg::*;

    localparam int SAT_W = (SQRT_BITS < MR_W) ? SQRT_BITS : MR_W;
    localparam int RW    = (SAT_W + 1) / 2;
    localparam int PAD_W = 2 * RW;
    localparam int CNT_W = (RW > 1) ? $clog2(RW) : 1;
    localparam logic [MR_W-1:0] RAD_LIM = MR_W'((64'd1 << SAT_W) - 64'd1);

    igs_root_state_t   state_reg, state_next;
    logic [PAD_W-1:0]  rad_reg, rad_next;
    logic [RW+1:0]     rem_reg, rem_next;
    logic [RW-1:0]     root_reg, root_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVR_W-1:0] div_reg, div_next;

    logic [MASS_W-1:0] mass_nz;
    logic [MR_W-1:0]   rad_full;
    logic [RW+1:0]     rem_try;
    logic [RW+1:0]     trial;

    // Radicand: mass taken as at least one, shifted and saturated.
    assign mass_nz  = (mass == '0) ? MASS_W'(1) : mass;
    assign rad_full = {mass_nz, 16'b0};
    assign rem_try  = {rem_reg[RW-1:0], rad_reg[PAD_W-1 -: 2]};
    assign trial    = {root_reg, 2'b01};

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= RS_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
        cnt_reg  <= cnt_next;
        div_reg  <= div_next;
    end

    // Next state and datapath.
    always_comb
    begin
        state_next = state_reg;
        rad_next   = rad_reg;
        rem_next   = rem_reg;
        root_next  = root_reg;
        cnt_next   = cnt_reg;
        div_next   = div_reg;
        unique case (state_reg)
            RS_IDLE:
            begin
            end
            RS_LOAD:
            begin
                rad_next   = (rad_full > RAD_LIM) ? PAD_W'(RAD_LIM) : PAD_W'(rad_full);
                rem_next   = '0;
                root_next  = '0;
                cnt_next   = CNT_W'(RW - 1);
                state_next = RS_STEP;
            end
            RS_STEP:
            begin
                rad_next = rad_reg << 2;
                if (rem_try >= trial)
                begin
                    rem_next  = rem_try - trial;
                    root_next = {root_reg[RW-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_try;
                    root_next = {root_reg[RW-2:0], 1'b0};
                end
                cnt_next = cnt_reg - CNT_W'(1);
                if (cnt_reg == '0)
                begin
                    state_next = RS_SCALE;
                end
            end
            RS_SCALE:
            begin
                div_next   = DIVR_W'(T_SCALE) * DIVR_W'(S_W'(root_reg));
                state_next = RS_IDLE;
            end
            default:
            begin
                state_next = RS_LOAD;
            end
        endcase
        if (start)
        begin
            state_next = RS_LOAD;
        end
    end

    assign busy    = (state_reg != RS_IDLE);
    assign divisor = div_reg;

endmodule

`default_nettype wire

/* hdl/igs_div_pipe.sv */
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; the caller must hold the divisor steady, the block does not enforce it.
// ----------------------------------------------------------------------------
`default_nettype none

`include "impedance_gain_scheduler_core_defines.svh"

module igs_div_pipe (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [igs_pkg::NUM_W-1:0]  num,
    input  logic [igs_pkg::DIVR_W-1:0] div,
    input  igs_pkg::igs_div_side_t     in_side,
    output logic                       out_valid,
    output logic [igs_pkg::QUO_W-1:0]  quot,
    output igs_pkg::igs_div_side_t     out_side
);

    import igs_pkg::*;

    localparam int CMP_W = DIVR_W + QUO_W;

    logic [QUO_W-1:0]  vld_reg;
    logic [NUM_W-1:0]  rem_reg  [QUO_W];
    logic [QUO_W-1:0]  quo_reg  [QUO_W];
    igs_div_side_t     side_reg [QUO_W];

    genvar s;
    generate
        for (s = 0; s < QUO_W; s++)
        begin : g_stage
            logic [NUM_W-1:0]    rem_in;
            logic [QUO_W-1:0]    quo_in;
            igs_div_side_t       side_in;
            logic                vld_in;
            logic [CMP_W-1:0]    div_sh;
            logic                ge;

            if (s == 0)
            begin : g_first
                assign rem_in  = num;
                assign quo_in  = '0;
                assign side_in = in_side;
                assign vld_in  = in_valid;
            end
            else
            begin : g_next
                assign rem_in  = rem_reg[s-1];
                assign quo_in  = quo_reg[s-1];
                assign side_in = side_reg[s-1];
                assign vld_in  = vld_reg[s-1];
            end

            // Compare against the divisor aligned to this quotient bit.
            assign div_sh = CMP_W'(div) << (QUO_W - 1 - s);
            assign ge     = (CMP_W'(rem_in) >= div_sh);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rem_reg[s]  <= ge ? NUM_W'(CMP_W'(rem_in) - div_sh) : rem_in;
                    quo_reg[s]  <= {quo_in[QUO_W-2:0], ge};
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[QUO_W-1];
    assign quot      = quo_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

    // The quotient must have fit its width, leaving a remainder below the divisor.
    `IGS_ASSERT_IMPL(a_rem_below_div, out_valid, CMP_W'(rem_reg[QUO_W-1]) < CMP_W'(div), "divider remainder not below divisor")

endmodule

`default_nettype wire

/* hdl/igs_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// Pipelined integer square root
// One root bit per stage, floor result, sideband carried alongside.
// ----------------------------------------------------------------------------
`default_nettype none

module igs_sqrt_pipe #(
    parameter int RAD_W = 30
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic [RAD_W-1:0]       rad,
    input  igs_pkg::igs_sqrt_side_t in_side,
    output logic                   out_valid,
    output logic [(RAD_W+1)/2-1:0] root,
    output igs_pkg::igs_sqrt_side_t out_side
);

    import igs_pkg::*;

    localparam int RW    = (RAD_W + 1) / 2;
    localparam int PAD_W = 2 * RW;

    logic [RW-1:0]     vld_reg;
    logic [PAD_W-1:0]  rad_reg  [RW];
    logic [RW+1:0]     rem_reg  [RW];
    logic [RW-1:0]     root_reg [RW];
    igs_sqrt_side_t    side_reg [RW];

    genvar s;
    generate
        for (s = 0; s < RW; s++)
        begin : g_stage
            logic [PAD_W-1:0] rad_in;
            logic [RW+1:0]    rem_in;
            logic [RW-1:0]    root_in;
            igs_sqrt_side_t   side_in;
            logic             vld_in;
            logic [RW+1:0]    rem_try;
            logic [RW+1:0]    trial;
            logic             ge;

            if (s == 0)
            begin : g_first
                assign rad_in  = PAD_W'(rad);
                assign rem_in  = '0;
                assign root_in = '0;
                assign side_in = in_side;
                assign vld_in  = in_valid;
            end
            else
            begin : g_next
                assign rad_in  = rad_reg[s-1];
                assign rem_in  = rem_reg[s-1];
                assign root_in = root_reg[s-1];
                assign side_in = side_reg[s-1];
                assign vld_in  = vld_reg[s-1];
            end

            // Bring down two radicand bits and try the next root bit.
            assign rem_try = {rem_in[RW-1:0], rad_in[PAD_W-1 -: 2]};
            assign trial   = {root_in, 2'b01};
            assign ge      = (rem_try >= trial);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    vld_reg[s] <= 1'b0;
                end
                else if (en)
                begin
                    vld_reg[s] <= vld_in;
                end
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    rad_reg[s]  <= rad_in << 2;
                    rem_reg[s]  <= ge ? (rem_try - trial) : rem_try;
                    root_reg[s] <= {root_in[RW-2:0], ge};
                    side_reg[s] <= side_in;
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[RW-1];
    assign root      = root_reg[RW-1];
    assign out_side  = side_reg[RW-1];

endmodule

`default_nettype wire

/* hdl/impedance_gain_scheduler_core.sv */
// ----------------------------------------------------------------------------
// Impedance gain scheduler core
// Per-axis stiffness and damping update from phase, position and interval.
// ----------------------------------------------------------------------------
// Throughput: one item per cycle unless the output stalls or the mass root
// sequencer is busy; the 24-stage divider and the square root pipeline each
// retire one quotient or root bit per stage.
// Reset: control clears; input ready then stays low while the mass square root
// sequencer runs, and again after each apparent_mass write.
`default_nettype none

`include "impedance_gain_scheduler_core_defines.svh"

module impedance_gain_scheduler_core #(
    parameter int SQRT_BITS = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_write,
    input  logic [igs_pkg::IDX_W-1:0]        cfg_index,
    input  logic [igs_pkg::CFG_W-1:0]        cfg_data,
    input  logic                             in_valid,
    output logic                             in_ready,
    input  logic [igs_pkg::PHASE_W-1:0]      phase,
    input  logic [igs_pkg::K_W-1:0]          stiffness_in,
    input  logic signed [igs_pkg::POS_W-1:0] position,
    input  logic [igs_pkg::T_W-1:0]          interval_us,
    output logic                             out_valid,
    input  logic                             out_ready,
    output logic [igs_pkg::K_W-1:0]          stiffness_out,
    output logic [igs_pkg::D_W-1:0]          damping_out
);

    import igs_pkg::*;

    localparam int PROD_W = K_W + MASS_W;
    localparam int SAT_W  = (SQRT_BITS < PROD_W) ? SQRT_BITS : PROD_W;
    localparam int RW     = (SAT_W + 1) / 2;
    localparam int DP_W   = FAC_W + RW;
    localparam logic [PROD_W-1:0] RAD_LIM = PROD_W'((64'd1 << SAT_W) - 64'd1);

    // Configuration registers.
    logic [K_W-1:0]          default_k_reg;
    logic [K_W-1:0]          min_k_reg;
    logic [K_W-1:0]          max_k_reg;
    logic signed [POS_W-1:0] height_reg;
    logic [MASS_W-1:0]       mass_reg;
    logic [FAC_W-1:0]        overdamp_reg;
    logic [DEC_W-1:0]        decay_reg;

    logic              en;
    logic              busy;
    logic [DIVR_W-1:0] divisor;

    // Stage A: captured item.
    logic               a_valid_reg;
    logic [PHASE_W-1:0] a_phase_reg;
    logic [K_W-1:0]     a_k_reg;
    logic               a_gt_reg;
    logic [T_W-1:0]     a_t_reg;

    // Stage B: products.
    logic               b_valid_reg;
    logic [PHASE_W-1:0] b_phase_reg;
    logic [K_W-1:0]     b_k_reg;
    logic               b_gt_reg;
    logic [KT_W-1:0]    b_kt_reg;
    logic [KD_W-1:0]    b_kdec_reg;

    // Stage C: dividend and chosen stiffness.
    logic               c_valid_reg;
    logic [NUM_W-1:0]   c_num_reg;
    igs_div_side_t      c_side_reg, c_side_next;
    logic [K_W-1:0]     k_decayed;

    // Divider outputs.
    logic               q_valid;
    logic [QUO_W-1:0]   q_quot;
    igs_div_side_t      q_side;

    // Stage D: final stiffness.
    logic               d_valid_reg;
    igs_sqrt_side_t     d_side_reg, d_side_next;
    logic [QUO_W:0]     k_grown;

    // Stage E: damping radicand.
    logic               e_valid_reg;
    logic [SAT_W-1:0]   e_rad_reg, e_rad_next;
    igs_sqrt_side_t     e_side_reg;
    logic [PROD_W-1:0]  k_mass;

    // Square root outputs.
    logic               r_valid;
    logic [RW-1:0]      r_root;
    igs_sqrt_side_t     r_side;

    // Output stage.
    logic               out_valid_reg;
    logic [K_W-1:0]     stiffness_out_reg;
    logic [D_W-1:0]     damping_out_reg, damping_out_next;
    logic [FAC_W-1:0]   fac;
    logic [DP_W-1:0]    damp_raw;

    // The whole pipeline advances unless a finished item waits at the output.
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en && !busy;

    // Configuration write decode.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            default_k_reg <= 18'd76800;
            min_k_reg     <= 18'd7680;
            max_k_reg     <= 18'd128000;
            height_reg    <= 18'sd9830;
            mass_reg      <= 12'd384;
            overdamp_reg  <= 8'd8;
            decay_reg     <= 16'd62259;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_DEFAULT_K: default_k_reg <= cfg_data[K_W-1:0];
                REG_MIN_K:     min_k_reg     <= cfg_data[K_W-1:0];
                REG_MAX_K:     max_k_reg     <= cfg_data[K_W-1:0];
                REG_HEIGHT:    height_reg    <= signed'(cfg_data[POS_W-1:0]);
                REG_MASS:      mass_reg      <= cfg_data[MASS_W-1:0];
                REG_OVERDAMP:  overdamp_reg  <= cfg_data[FAC_W-1:0];
                REG_DECAY:     decay_reg     <= cfg_data[DEC_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Growth divisor from the apparent mass.
    igs_root_unit #(
        .SQRT_BITS (SQRT_BITS)
    ) u_root (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cfg_write && (cfg_index == REG_MASS)),
        .mass    (mass_reg),
        .busy    (busy),
        .divisor (divisor)
    );

    // Valid bits of the local stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            e_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid && in_ready;
            b_valid_reg   <= a_valid_reg;
            c_valid_reg   <= b_valid_reg;
            d_valid_reg   <= q_valid;
            e_valid_reg   <= d_valid_reg;
            out_valid_reg <= r_valid;
        end
    end

    // Stage C combinational: decayed stiffness and per-phase selection.
    always_comb
    begin
        k_decayed = b_kdec_reg[KD_W-1:DEC_W];
        if (k_decayed < min_k_reg)
        begin
            k_decayed = min_k_reg;
        end
        c_side_next.k        = b_k_reg;
        c_side_next.grow     = 1'b0;
        c_side_next.interact = 1'b0;
        unique case (b_phase_reg)
            PH_FREE:     c_side_next.k = default_k_reg;
            PH_INTERACT:
            begin
                c_side_next.k        = k_decayed;
                c_side_next.interact = 1'b1;
            end
            PH_RECOVER:  c_side_next.grow = b_gt_reg;
            default:
            begin
            end
        endcase
    end

    // Stage D combinational: grown stiffness clamped at the maximum.
    always_comb
    begin
        k_grown              = (QUO_W + 1)'(q_side.k) + (QUO_W + 1)'(q_quot);
        d_side_next.interact = q_side.interact;
        d_side_next.k        = q_side.k;
        if (q_side.grow)
        begin
            d_side_next.k = (k_grown > (QUO_W + 1)'(max_k_reg)) ? max_k_reg
                                                                 : k_grown[K_W-1:0];
        end
    end

    // Stage E combinational: stiffness times mass, saturated for the root.
    assign k_mass     = PROD_W'(d_side_reg.k) * PROD_W'(mass_reg);
    assign e_rad_next = (k_mass > RAD_LIM) ? RAD_LIM[SAT_W-1:0] : k_mass[SAT_W-1:0];

    // Output stage combinational: damping factor times root, saturated.
    assign fac              = r_side.interact ? overdamp_reg : FAC_TWO;
    assign damp_raw         = DP_W'(fac) * DP_W'(r_root);
    assign damping_out_next = (damp_raw > DP_W'(DAMP_MAX)) ? DAMP_MAX : D_W'(damp_raw);

    // Payload registers of the local stages.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_phase_reg       <= phase;
            a_k_reg           <= stiffness_in;
            a_gt_reg          <= (position > height_reg);
            a_t_reg           <= (interval_us > T_MAX) ? T_MAX : interval_us;
            b_phase_reg       <= a_phase_reg;
            b_k_reg           <= a_k_reg;
            b_gt_reg          <= a_gt_reg;
            b_kt_reg          <= KT_W'(a_k_reg) * KT_W'(a_t_reg);
            b_kdec_reg        <= KD_W'(a_k_reg) * KD_W'(decay_reg);
            c_num_reg         <= NUM_W'(b_kt_reg) * NUM_W'(GAIN_Q16);
            c_side_reg        <= c_side_next;
            d_side_reg        <= d_side_next;
            e_rad_reg         <= e_rad_next;
            e_side_reg        <= d_side_reg;
            stiffness_out_reg <= r_side.k;
            damping_out_reg   <= damping_out_next;
        end
    end

    // Growth step division.
    igs_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (c_valid_reg),
        .num       (c_num_reg),
        .div       (divisor),
        .in_side   (c_side_reg),
        .out_valid (q_valid),
        .quot      (q_quot),
        .out_side  (q_side)
    );

    // Damping square root.
    igs_sqrt_pipe #(
        .RAD_W (SAT_W)
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (e_valid_reg),
        .rad       (e_rad_reg),
        .in_side   (e_side_reg),
        .out_valid (r_valid),
        .root      (r_root),
        .out_side  (r_side)
    );

    assign out_valid     = out_valid_reg;
    assign stiffness_out = stiffness_out_reg;
    assign damping_out   = damping_out_reg;

    // No item may enter while the mass root is being recomputed.
    `IGS_ASSERT_IMPL(a_busy_blocks_input, busy, !in_ready, "input ready while mass root busy")
    // A mass write must start the root sequencer.
    `IGS_ASSERT_NEXT(a_mass_write_busy, cfg_write && (cfg_index == REG_MASS), busy, "mass write did not start root")
    // A stall must hold the item at the divider entry.
    `IGS_ASSERT_NEXT(a_stall_holds_entry, c_valid_reg && !en, c_valid_reg, "stall dropped divider entry")

endmodule

`default_nettype wire

/* sim/tb_impedance_gain_scheduler_core.sv */
// ----------------------------------------------------------------------------
// Impedance gain scheduler core testbench
// Drives phase, stiffness, position and interval items through the core under
// several register settings. Random idling sits on both sides of the core.
// Every result is compared field by field with an in-bench prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_impedance_gain_scheduler_core;

    import igs_pkg::*;

    localparam int ROOT_BITS      = 32;
    localparam int IDLE_LIMIT     = 20000;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_ITEMS   = 850;
    localparam int QUIET_TAIL     = 120;

    typedef struct packed {
        logic [PHASE_W-1:0]     ph;
        logic [K_W-1:0]         k;
        logic signed [POS_W-1:0] pos;
        logic [T_W-1:0]         t;
    } gain_item_t;

    typedef struct packed {
        logic [K_W-1:0] k;
        logic [D_W-1:0] d;
    } gain_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    cfg_write;
    logic [IDX_W-1:0]        cfg_index;
    logic [CFG_W-1:0]        cfg_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [PHASE_W-1:0]      phase;
    logic [K_W-1:0]          stiffness_in;
    logic signed [POS_W-1:0] position;
    logic [T_W-1:0]          interval_us;
    logic                    out_valid;
    logic                    out_ready;
    logic [K_W-1:0]          stiffness_out;
    logic [D_W-1:0]          damping_out;

    // Shadow copy of the register file.
    logic [K_W-1:0]    sh_default_k;
    logic [K_W-1:0]    sh_min_k;
    logic [K_W-1:0]    sh_max_k;
    logic [POS_W-1:0]  sh_height;
    logic [MASS_W-1:0] sh_mass;
    logic [FAC_W-1:0]  sh_overdamp;
    logic [DEC_W-1:0]  sh_decay;

    gain_item_t   pending_items[$];
    gain_result_t expected_gains[$];

    int  mismatch_count;
    int  idle_cycles;
    bit  quiet_mode;
    bit  long_hold_req;
    bit  in_fire;

    impedance_gain_scheduler_core #(.SQRT_BITS(ROOT_BITS)) u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .phase         (phase),
        .stiffness_in  (stiffness_in),
        .position      (position),
        .interval_us   (interval_us),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .stiffness_out (stiffness_out),
        .damping_out   (damping_out)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Floor square root with the radicand saturated to ROOT_BITS bits.
    function automatic longint unsigned isqrt(input longint unsigned v);
        longint unsigned lim;
        longint unsigned r;
        longint unsigned b;
        lim = (64'd1 << ROOT_BITS) - 1;
        r = 0;
        b = 64'd1 << 62;
        if (v > lim)
            v = lim;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [D_W-1:0] damping_for(input longint unsigned fac,
                                                   input longint unsigned k);
        longint unsigned d;
        d = fac * isqrt(k * sh_mass);
        return (d > DAMP_MAX) ? DAMP_MAX : d[D_W-1:0];
    endfunction

    // Predicted stiffness and damping for one item.
    function automatic gain_result_t predict_gain(input gain_item_t it);
        gain_result_t    res;
        longint unsigned k;
        longint unsigned t;
        longint unsigned m;
        longint unsigned s;
        longint unsigned delta;
        logic [D_W-1:0]  d;
        k = it.k;
        t = (it.t > T_MAX) ? T_MAX : it.t;
        case (it.ph)
            PH_FREE:
            begin
                k = sh_default_k;
                d = damping_for(2, k);
            end
            PH_INTERACT:
            begin
                k = (k * sh_decay) >> 16;
                if (k < sh_min_k)
                    k = sh_min_k;
                d = damping_for(sh_overdamp, k);
            end
            PH_RECOVER:
            begin
                if (it.pos > $signed(sh_height))
                begin
                    m = (sh_mass == 0) ? 1 : sh_mass;
                    s = isqrt(m << 16);
                    if (s == 0)
                        s = 1;
                    delta = (64'd84157 * k * t) / (64'd16000000 * s);
                    k = k + delta;
                    if (k > sh_max_k)
                        k = sh_max_k;
                end
                d = damping_for(2, k);
            end
            default:
                d = damping_for(2, k);
        endcase
        res.k = k[K_W-1:0];
        res.d = d;
        return res;
    endfunction

    // Input driver: offers queued items with random idle bursts.
    int in_gap;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_gap = 0;
        end
        else if (!in_valid || in_fire)
        begin
            if (in_gap > 0)
            begin
                in_gap = in_gap - 1;
                in_valid <= 1'b0;
            end
            else if (pending_items.size() > 0)
            begin
                gain_item_t it;
                it = pending_items.pop_front();
                phase        <= it.ph;
                stiffness_in <= it.k;
                position     <= it.pos;
                interval_us  <= it.t;
                in_valid     <= 1'b1;
                if (!quiet_mode && $urandom_range(0, 5) == 0)
                    in_gap = $urandom_range(1, 13);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Accepted input items feed the prediction.
    always @(posedge clk)
    begin
        in_fire <= rst_n && in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            expected_gains.push_back(predict_gain({phase, stiffness_in, position,
                                                   interval_us}));
        end
    end

    // Result side: random stalls plus one long hold-off on request.
    int out_gap;
    int hold_left;
    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap = 0;
            hold_left = 0;
        end
        else if (long_hold_req && hold_left == 0 && out_gap >= 0)
        begin
            hold_left = 300;
            out_ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            out_ready <= (hold_left == 0);
        end
        else if (out_gap > 0)
        begin
            out_gap = out_gap - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!quiet_mode && $urandom_range(0, 6) == 0)
                out_gap = $urandom_range(1, 13);
        end
    end

    // Result checker.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            gain_result_t want;
            if (expected_gains.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("Unexpected result: k=%0d d=%0d", stiffness_out,
                             damping_out);
            end
            else
            begin
                want = expected_gains.pop_front();
                if (want.k !== stiffness_out || want.d !== damping_out)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("Mismatch: expected k=%0d d=%0d, got k=%0d d=%0d",
                                 want.k, want.d, stiffness_out, damping_out);
                end
            end
        end
    end

    // Watchdog on cycles without any accepted item.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_DEFAULT_K: sh_default_k = val;
            REG_MIN_K:     sh_min_k = val;
            REG_MAX_K:     sh_max_k = val;
            REG_HEIGHT:    sh_height = val;
            REG_MASS:      sh_mass = val[MASS_W-1:0];
            REG_OVERDAMP:  sh_overdamp = val[FAC_W-1:0];
            default:       sh_decay = val[DEC_W-1:0];
        endcase
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic write_all(input logic [K_W-1:0] dk, input logic [K_W-1:0] mink,
                             input logic [K_W-1:0] maxk, input logic [POS_W-1:0] h,
                             input logic [MASS_W-1:0] m, input logic [FAC_W-1:0] f,
                             input logic [DEC_W-1:0] dec);
        write_reg(REG_DEFAULT_K, dk);
        write_reg(REG_MIN_K, mink);
        write_reg(REG_MAX_K, maxk);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_MASS, CFG_W'(m));
        write_reg(REG_OVERDAMP, CFG_W'(f));
        write_reg(REG_DECAY, CFG_W'(dec));
    endtask

    // Waits until everything queued has come back, then lets the core settle.
    task automatic drain();
        wait (pending_items.size() == 0 && !in_valid && expected_gains.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic gain_item_t rand_item();
        gain_item_t it;
        int sel;
        sel = $urandom_range(0, 19);
        it.ph  = (sel == 0) ? 2'd3 : PHASE_W'($urandom_range(0, 2));
        it.k   = ($urandom_range(0, 3) == 0) ? K_W'($urandom)
                                             : K_W'($urandom_range(0, 140000));
        it.pos = POS_W'($urandom);
        case ($urandom_range(0, 4))
            0: it.t = T_W'($urandom);
            1: it.t = T_W'($urandom_range(0, 1000000));
            default: it.t = T_W'($urandom_range(0, 20000));
        endcase
        return it;
    endfunction

    function automatic gain_item_t mk(input logic [1:0] ph, input logic [K_W-1:0] k,
                                      input logic [POS_W-1:0] pos,
                                      input logic [T_W-1:0] t);
        gain_item_t it;
        it.ph = ph;
        it.k = k;
        it.pos = pos;
        it.t = t;
        return it;
    endfunction

    // Stimulus and end of run.
    initial
    begin
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        phase = '0;
        stiffness_in = '0;
        position = '0;
        interval_us = '0;
        mismatch_count = 0;
        idle_cycles = 0;
        quiet_mode = 1'b0;
        long_hold_req = 1'b0;
        sh_default_k = 76800;
        sh_min_k = 7680;
        sh_max_k = 128000;
        sh_height = 9830;
        sh_mass = 384;
        sh_overdamp = 8;
        sh_decay = 62259;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed items at reset settings: every phase and the edge cases.
        pending_items.push_back(mk(PH_FREE, 0, 0, 0));
        pending_items.push_back(mk(PH_FREE, 18'h3FFFF, 18'h1FFFF, 20'hFFFFF));
        pending_items.push_back(mk(PH_INTERACT, 0, 0, 0));
        pending_items.push_back(mk(PH_INTERACT, 18'h3FFFF, 18'h20000, 5));
        pending_items.push_back(mk(PH_INTERACT, 100000, 0, 0));
        pending_items.push_back(mk(PH_RECOVER, 0, 18'h1FFFF, 1000000));
        pending_items.push_back(mk(PH_RECOVER, 50000, 18'h1FFFF, 1000000));
        pending_items.push_back(mk(PH_RECOVER, 50000, 18'h1FFFF, 20'hFFFFF));
        pending_items.push_back(mk(PH_RECOVER, 50000, 9830, 1000000));
        pending_items.push_back(mk(PH_RECOVER, 50000, 9831, 5000));
        pending_items.push_back(mk(PH_RECOVER, 50000, 18'h20000, 1000000));
        pending_items.push_back(mk(PH_RECOVER, 200000, 18'h1FFFF, 0));
        pending_items.push_back(mk(PH_RECOVER, 18'h3FFFF, 18'h1FFFF, 20'hFFFFF));
        pending_items.push_back(mk(2'd3, 18'h3FFFF, 0, 0));
        pending_items.push_back(mk(2'd3, 1234, 18'h2AAAA, 20'h55555));
        drain();

        // Extreme settings, zero mass among them.
        write_all(18'h3FFFF, 18'h3FFFF, 0, 18'h20000, 0, 255, 65535);
        pending_items.push_back(mk(PH_FREE, 1, 0, 0));
        pending_items.push_back(mk(PH_INTERACT, 18'h3FFFF, 0, 0));
        pending_items.push_back(mk(PH_RECOVER, 1000, 0, 1000000));
        pending_items.push_back(mk(PH_RECOVER, 0, 18'h20000, 1000000));
        drain();
        write_all(0, 0, 18'h3FFFF, 18'h1FFFF, 4095, 0, 0);
        pending_items.push_back(mk(PH_FREE, 9, 0, 0));
        pending_items.push_back(mk(PH_INTERACT, 18'h3FFFF, 0, 0));
        pending_items.push_back(mk(PH_RECOVER, 18'h3FFFF, 18'h1FFFF, 1000000));
        pending_items.push_back(mk(2'd3, 18'h3FFFF, 0, 0));
        drain();

        // Random phases over a handful of settings.
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 0)
                write_all(76800, 7680, 128000, 9830, 384, 8, 62259);
            else
                write_all(K_W'($urandom), K_W'($urandom_range(0, 20000)),
                          K_W'($urandom_range(60000, 262143)), POS_W'($urandom),
                          MASS_W'($urandom_range(1, 4095)), FAC_W'($urandom),
                          DEC_W'($urandom));
            if (ph == 1)
                long_hold_req = 1'b1;
            if (ph == 4)
                quiet_mode = 1'b1;
            for (int i = 0; i < RANDOM_ITEMS / 5; i++)
                pending_items.push_back(rand_item());
            if (ph == 1)
            begin
                repeat (40) @(posedge clk);
                long_hold_req = 1'b0;
            end
            drain();
        end

        if (mismatch_count == 0 && expected_gains.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

/* sim.f */
+incdir+hdl
hdl/igs_pkg.sv
hdl/igs_root_unit.sv
hdl/igs_div_pipe.sv
hdl/igs_sqrt_pipe.sv
hdl/impedance_gain_scheduler_core.sv
sim/tb_impedance_gain_scheduler_core.sv
